[design/pccc_pkg.sv]
// Shared constants and types for the point-in-circle collision check.
`default_nettype none

package pccc_pkg;

   // table geometry
   localparam int MAX_OBSTACLES = 64;
   localparam int COORD_BITS    = 16;
   localparam int SLOT_BITS     = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam int COUNT_BITS    = $clog2(MAX_OBSTACLES + 1);
   localparam int ENTRY_W       = 2 * COORD_BITS;

   // field widths fixed by the item format
   localparam int INDEX_BITS    = 6;
   localparam int OBS_CNT_BITS  = 7;
   localparam int LIMIT_BITS    = 15;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 15;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 8;

   // distance arithmetic
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int SQ_BITS   = 2 * COORD_BITS;
   localparam int SUM_BITS  = SQ_BITS + 1;
   localparam int RSQ_BITS  = 2 * LIMIT_BITS;
   localparam int CMP_BITS  = (SUM_BITS > RSQ_BITS) ? SUM_BITS : RSQ_BITS;
   localparam int MAG_BITS  = (COORD_BITS > LIMIT_BITS) ? COORD_BITS : LIMIT_BITS;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_OBSTACLE_COUNT  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OBSTACLE_RADIUS = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HALF_WIDTH      = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HALF_LENGTH     = 2'd3;

   // item kinds
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   // status of the distance pipeline toward the sequencer
   typedef struct packed {
      logic busy;   // some stage holds a slot in flight
      logic hit;    // last stage reports a slot that contains the point
   } dist_status_type;

endpackage

`default_nettype wire

[design/pccc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pccc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire                                      clock,
   input  wire                                      wr_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]                         wr_data,
   input  wire                                      rd_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/pccc_dist.sv]
// Pipelined squared-distance test of the query point against one centre per cycle.
`default_nettype none

module pccc_dist (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    issue,      // table read issued this cycle
   input  wire  [pccc_pkg::ENTRY_W-1:0]           centre,     // {y, x} read data, next cycle
   input  wire  signed [pccc_pkg::COORD_BITS-1:0] query_x,
   input  wire  signed [pccc_pkg::COORD_BITS-1:0] query_y,
   input  wire  [pccc_pkg::LIMIT_BITS-1:0]        radius,
   output pccc_pkg::dist_status_type              status
);

   logic                                 v0_ff, v1_ff, v2_ff, v3_ff;
   logic [pccc_pkg::RSQ_BITS-1:0]        rsq_ff;
   logic [pccc_pkg::COORD_BITS-1:0]      dx1_ff, dy1_ff;
   logic [pccc_pkg::SQ_BITS-1:0]         sqx2_ff, sqy2_ff;
   logic                                 hit3_ff;

   logic signed [pccc_pkg::COORD_BITS-1:0] cx, cy;
   logic signed [pccc_pkg::DIFF_BITS-1:0]  diff_x, diff_y, neg_x, neg_y;
   logic [pccc_pkg::COORD_BITS-1:0]        dx1_in, dy1_in;
   logic [pccc_pkg::SUM_BITS-1:0]          sum3;
   logic                                   hit3_in;

   assign cx = centre[pccc_pkg::COORD_BITS-1:0];
   assign cy = centre[pccc_pkg::ENTRY_W-1:pccc_pkg::COORD_BITS];

   // stage 1: absolute coordinate differences
   always_comb begin
      diff_x = pccc_pkg::DIFF_BITS'(query_x) - pccc_pkg::DIFF_BITS'(cx);
      diff_y = pccc_pkg::DIFF_BITS'(query_y) - pccc_pkg::DIFF_BITS'(cy);
      neg_x  = -diff_x;
      neg_y  = -diff_y;
      dx1_in = diff_x[pccc_pkg::DIFF_BITS-1] ? neg_x[pccc_pkg::COORD_BITS-1:0]
                                             : diff_x[pccc_pkg::COORD_BITS-1:0];
      dy1_in = diff_y[pccc_pkg::DIFF_BITS-1] ? neg_y[pccc_pkg::COORD_BITS-1:0]
                                             : diff_y[pccc_pkg::COORD_BITS-1:0];
   end

   // stage 3: sum of squares against radius squared, strict
   always_comb begin
      sum3    = pccc_pkg::SUM_BITS'(sqx2_ff) + pccc_pkg::SUM_BITS'(sqy2_ff);
      hit3_in = v2_ff &&
                (pccc_pkg::CMP_BITS'(sum3) < pccc_pkg::CMP_BITS'(rsq_ff));
   end

   // data path registers
   always_ff @(posedge clock) begin
      rsq_ff  <= pccc_pkg::RSQ_BITS'(radius) * pccc_pkg::RSQ_BITS'(radius);
      dx1_ff  <= dx1_in;
      dy1_ff  <= dy1_in;
      sqx2_ff <= pccc_pkg::SQ_BITS'(dx1_ff) * pccc_pkg::SQ_BITS'(dx1_ff);
      sqy2_ff <= pccc_pkg::SQ_BITS'(dy1_ff) * pccc_pkg::SQ_BITS'(dy1_ff);
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff   <= 1'b0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         hit3_ff <= 1'b0;
      end else begin
         v0_ff   <= issue;
         v1_ff   <= v0_ff;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         hit3_ff <= hit3_in;
      end
   end

   // {busy, hit}
   assign status = {v0_ff | v1_ff | v2_ff | v3_ff, v3_ff & hit3_ff};

endmodule

`default_nettype wire

[design/point_circle_collision_check.sv]
// Top level: obstacle table, query sequencer, border test and result register.
// Loads are taken back to back while idle; a query walks the table with one table read per
//   obstacle per cycle, then drains the pipeline, and no request is taken until it is done.
//   An untaken result stalls the next query in its drain and so holds the input off.
//   Reset (synchronous, active high) clears the sequencer, the result and all configuration
//   registers; the obstacle table holds garbage until loaded.
`default_nettype none

module point_circle_collision_check (
   input  wire                                  clock,
   input  wire                                  reset,
   // request channel
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [pccc_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // entry_index, coord_x, coord_y, 0 pad
   input  wire                                  req_tuser,  // action
   // response channel
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [pccc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // point_valid, 0 pad
   // configuration write port
   input  wire                                  csr_we,
   input  wire  [pccc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire  [pccc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN
   } state_type;

   // request fields
   logic [pccc_pkg::INDEX_BITS-1:0]        req_index;
   logic signed [pccc_pkg::COORD_BITS-1:0] req_x, req_y;
   logic                                   req_accept;

   assign req_index  = req_tdata[pccc_pkg::INDEX_BITS-1:0];
   assign req_x      = req_tdata[pccc_pkg::INDEX_BITS +: pccc_pkg::COORD_BITS];
   assign req_y      = req_tdata[pccc_pkg::INDEX_BITS + pccc_pkg::COORD_BITS +:
                                 pccc_pkg::COORD_BITS];
   assign req_accept = req_tvalid & req_tready;

   // configuration registers
   logic [pccc_pkg::OBS_CNT_BITS-1:0] obs_count_ff;
   logic [pccc_pkg::LIMIT_BITS-1:0]   radius_ff, half_width_ff, half_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         obs_count_ff   <= '0;
         radius_ff      <= '0;
         half_width_ff  <= '0;
         half_length_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            pccc_pkg::CSR_OBSTACLE_COUNT: begin
               obs_count_ff <= csr_wdata[pccc_pkg::OBS_CNT_BITS-1:0];
            end
            pccc_pkg::CSR_OBSTACLE_RADIUS: begin
               radius_ff <= csr_wdata[pccc_pkg::LIMIT_BITS-1:0];
            end
            pccc_pkg::CSR_HALF_WIDTH: begin
               half_width_ff <= csr_wdata[pccc_pkg::LIMIT_BITS-1:0];
            end
            pccc_pkg::CSR_HALF_LENGTH: begin
               half_length_ff <= csr_wdata[pccc_pkg::LIMIT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer registers
   state_type                              state_ff, state_in;
   logic [pccc_pkg::COUNT_BITS-1:0]        slot_ff, slot_in;
   logic [pccc_pkg::COUNT_BITS-1:0]        count_ff, count_in;
   logic                                   hit_ff, hit_in;
   logic                                   border_bad_ff, border_bad_in;
   logic signed [pccc_pkg::COORD_BITS-1:0] qx_ff, qy_ff;
   logic                                   rsp_tvalid_ff, rsp_tvalid_in;
   logic                                   rsp_valid_bit_ff, rsp_valid_bit_in;

   pccc_pkg::dist_status_type              dist_status;
   logic                                   load_we;
   logic                                   walk_re;
   logic [pccc_pkg::SLOT_BITS-1:0]         load_addr;
   logic [pccc_pkg::ENTRY_W-1:0]           centre_rd;
   logic                                   load_in_range;
   logic                                   rsp_free;

   // border test on the incoming point
   logic signed [pccc_pkg::COORD_BITS-1:0] neg_x, neg_y;
   logic [pccc_pkg::COORD_BITS-1:0]        mag_x, mag_y;
   logic                                   x_out, y_out;

   always_comb begin
      neg_x = -req_x;
      neg_y = -req_y;
      mag_x = req_x[pccc_pkg::COORD_BITS-1] ? neg_x : req_x;
      mag_y = req_y[pccc_pkg::COORD_BITS-1] ? neg_y : req_y;
      x_out = (half_width_ff != '0) &&
              (pccc_pkg::MAG_BITS'(mag_x) > pccc_pkg::MAG_BITS'(half_width_ff));
      y_out = (half_length_ff != '0) &&
              (pccc_pkg::MAG_BITS'(mag_y) > pccc_pkg::MAG_BITS'(half_length_ff));
   end

   assign req_tready    = (state_ff == ST_IDLE);
   assign load_in_range = (32'(req_index) < 32'(pccc_pkg::MAX_OBSTACLES));
   assign load_we       = req_accept && (req_tuser == pccc_pkg::ACTION_LOAD) && load_in_range;
   assign load_addr     = pccc_pkg::SLOT_BITS'(req_index);
   assign walk_re       = (state_ff == ST_WALK) && (slot_ff != count_ff);
   assign rsp_free      = !rsp_tvalid_ff || rsp_tready;

   // next state and registered outputs
   always_comb begin
      state_in         = state_ff;
      slot_in          = slot_ff;
      count_in         = count_ff;
      hit_in           = hit_ff | dist_status.hit;
      border_bad_in    = border_bad_ff;
      rsp_tvalid_in    = rsp_tvalid_ff && !rsp_tready;
      rsp_valid_bit_in = rsp_valid_bit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == pccc_pkg::ACTION_QUERY)) begin
               slot_in       = '0;
               hit_in        = 1'b0;
               border_bad_in = x_out | y_out;
               if (32'(obs_count_ff) > 32'(pccc_pkg::MAX_OBSTACLES)) begin
                  count_in = pccc_pkg::COUNT_BITS'(pccc_pkg::MAX_OBSTACLES);
               end else begin
                  count_in = pccc_pkg::COUNT_BITS'(obs_count_ff);
               end
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_re) begin
               slot_in = slot_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // all slots accumulated once the pipeline is empty
            if (!dist_status.busy && rsp_free) begin
               rsp_tvalid_in    = 1'b1;
               rsp_valid_bit_in = !(hit_ff | border_bad_ff);
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         slot_ff          <= '0;
         count_ff         <= '0;
         hit_ff           <= 1'b0;
         border_bad_ff    <= 1'b0;
         rsp_tvalid_ff    <= 1'b0;
         rsp_valid_bit_ff <= 1'b0;
      end else begin
         state_ff         <= state_in;
         slot_ff          <= slot_in;
         count_ff         <= count_in;
         hit_ff           <= hit_in;
         border_bad_ff    <= border_bad_in;
         rsp_tvalid_ff    <= rsp_tvalid_in;
         rsp_valid_bit_ff <= rsp_valid_bit_in;
      end
   end

   // query point
   always_ff @(posedge clock) begin
      if (req_accept) begin
         qx_ff <= req_x;
         qy_ff <= req_y;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = pccc_pkg::RSP_DATA_BITS'(rsp_valid_bit_ff);

   // obstacle centre table, {y, x} per slot
   pccc_ram #(
      .WIDTH (pccc_pkg::ENTRY_W),
      .DEPTH (pccc_pkg::MAX_OBSTACLES)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_we),
      .wr_addr (load_addr),
      .wr_data ({req_y, req_x}),
      .rd_en   (walk_re),
      .rd_addr (slot_ff[pccc_pkg::SLOT_BITS-1:0]),
      .rd_data (centre_rd)
   );

   // distance pipeline
   pccc_dist u_dist (
      .clock   (clock),
      .reset   (reset),
      .issue   (walk_re),
      .centre  (centre_rd),
      .query_x (qx_ff),
      .query_y (qy_ff),
      .radius  (radius_ff),
      .status  (dist_status)
   );

   // slots in flight only while a query is being worked
   a_busy_not_idle: assert property (@(posedge clock) disable iff (reset)
      dist_status.busy |-> (state_ff != ST_IDLE))
      else $error("distance pipeline busy while idle");

   // the walk never runs past the clamped count
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (slot_ff <= count_ff))
      else $error("slot counter beyond obstacle count");

   // a table load never coincides with a walk read
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(load_we && walk_re))
      else $error("table written during walk");

   // a finished query waits while the previous result is still held
   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DRAIN) && !dist_status.busy && rsp_tvalid_ff && !rsp_tready)
      |=> (state_ff == ST_DRAIN) && rsp_tvalid_ff)
      else $error("result overwritten before taken");

endmodule

`default_nettype wire
